/* src/bpt_pkg.sv */
package bpt_pkg;

  localparam int unsigned NumCal    = 6;
  localparam int unsigned CalIdxW   = 3;
  localparam int unsigned CalW      = 32;
  localparam int unsigned QueueDepth = 2;

  localparam logic [2:0] CalT1T2 = 3'd0;
  localparam logic [2:0] CalT3P1 = 3'd1;
  localparam logic [2:0] CalP2P3 = 3'd2;
  localparam logic [2:0] CalP4P5 = 3'd3;
  localparam logic [2:0] CalP6P7 = 3'd4;
  localparam logic [2:0] CalP8P9 = 3'd5;

  localparam logic [20:0] PAdcOffset = 21'd1048576;
  localparam logic [32:0] FineOffset = 33'd128000;
  localparam logic [11:0] PScale     = 12'd3125;
  localparam logic [63:0] POne47     = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } bpt_in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_q24_8;
    logic               pressure_invalid;
  } bpt_out_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } bpt_cal_t;

  // Values that ride along the divider beside the quotient.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic        invalid;
    logic        qneg;
  } bpt_side_t;

  // Low 64 bits of a 64-bit word times a signed 16-bit coefficient.
  function automatic logic [63:0] mul_s64_s16(input logic [63:0] a, input logic [15:0] c);
    logic [79:0] pr;
    logic [63:0] corr;
    begin
      pr   = {16'b0, a} * {64'b0, c};
      corr = c[15] ? {a[47:0], 16'b0} : 64'b0;
      return pr[63:0] - corr;
    end
  endfunction

  // Low 64 bits of a 64-bit word times an unsigned 16-bit coefficient.
  function automatic logic [63:0] mul_u64_u16(input logic [63:0] a, input logic [15:0] c);
    logic [79:0] pr;
    begin
      pr = {16'b0, a} * {64'b0, c};
      return pr[63:0];
    end
  endfunction

endpackage

/* src/bpt_cfg.sv */
module bpt_cfg import bpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CalIdxW-1:0] cfg_idx_i,
  input  logic [CalW-1:0]    cfg_wdata_i,
  output bpt_cal_t           cal_o
);

  logic [CalW-1:0] regs_q [NumCal];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCal; i++) regs_q[i] <= '0;
    end else if (cfg_we_i && (32'(cfg_idx_i) < NumCal)) begin
      regs_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    cal_o.t1 = regs_q[CalT1T2][15:0];
    cal_o.t2 = regs_q[CalT1T2][31:16];
    cal_o.t3 = regs_q[CalT3P1][15:0];
    cal_o.p1 = regs_q[CalT3P1][31:16];
    cal_o.p2 = regs_q[CalP2P3][15:0];
    cal_o.p3 = regs_q[CalP2P3][31:16];
    cal_o.p4 = regs_q[CalP4P5][15:0];
    cal_o.p5 = regs_q[CalP4P5][31:16];
    cal_o.p6 = regs_q[CalP6P7][15:0];
    cal_o.p7 = regs_q[CalP6P7][31:16];
    cal_o.p8 = regs_q[CalP8P9][15:0];
    cal_o.p9 = regs_q[CalP8P9][31:16];
  end

endmodule

/* src/bpt_front.sv */
module bpt_front import bpt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  bpt_in_t in_data_i,
  output logic    q_valid_o,
  input  logic    q_ready_i,
  output bpt_in_t q_data_o
);

  bpt_in_t    mem_q [QueueDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'(QueueDepth));
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

endmodule

/* src/bpt_div.sv */
module bpt_div import bpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] dividend_i,
  input  logic [30:0] divisor_i,
  input  bpt_side_t   side_i,
  output logic        valid_o,
  output logic [63:0] quot_o,
  output bpt_side_t   side_o
);

  localparam int unsigned Steps  = 2;
  localparam int unsigned Stages = 64 / Steps;

  logic        v_q   [Stages];
  logic [31:0] rem_q [Stages];
  logic [63:0] dq_q  [Stages];
  logic [30:0] mb_q  [Stages];
  bpt_side_t   sd_q  [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic        v_in;
    logic [31:0] rem_in, rem_d;
    logic [63:0] dq_in, dq_d;
    logic [30:0] mb_in;
    bpt_side_t   sd_in;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = '0;
      assign dq_in  = dividend_i;
      assign mb_in  = divisor_i;
      assign sd_in  = side_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign mb_in  = mb_q[k-1];
      assign sd_in  = sd_q[k-1];
    end

    // Restoring division, one quotient bit per step.
    always_comb begin
      rem_d = rem_in;
      dq_d  = dq_in;
      for (int s = 0; s < Steps; s++) begin
        rem_d = {rem_d[30:0], dq_d[63]};
        dq_d  = {dq_d[62:0], 1'b0};
        if (rem_d >= {1'b0, mb_in}) begin
          rem_d = rem_d - {1'b0, mb_in};
          dq_d[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        dq_q[k]  <= dq_d;
        mb_q[k]  <= mb_in;
        sd_q[k]  <= sd_in;
      end
    end
  end

  assign valid_o = v_q[Stages-1];
  assign quot_o  = dq_q[Stages-1];
  assign side_o  = sd_q[Stages-1];

endmodule

/* src/bpt_back.sv */
module bpt_back import bpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bpt_cal_t cal_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bpt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bpt_out_t out_data_o
);

  logic adv;
  logic [9:0] v_q;
  logic [3:0] qv_q;

  // Stage registers, named after the stage that writes them.
  logic [33:0] s1_ta_q, s1_dd_q;
  logic [19:0] s1_adc_q, s2_adc_q, s3_adc_q, s4_adc_q, s5_adc_q, s6_adc_q, s7_adc_q;
  logic [22:0] s2_ta_q;
  logic [37:0] s2_tb_q;
  logic [31:0] s3_fine_q;
  logic [31:0] s4_temp_q, s4_absa_q;
  logic [32:0] s4_a_q;
  logic [31:0] s5_temp_q, s5_fine_q, s6_temp_q, s6_fine_q, s7_temp_q, s7_fine_q;
  logic [31:0] s8_temp_q, s8_fine_q, s9_temp_q, s9_fine_q, s4_fine_q;
  logic [63:0] s5_asq_q;
  logic [48:0] s5_ap5_q, s5_ap2_q, s6_ap5_q, s6_ap2_q;
  logic [63:0] s6_b1_q, s6_a1_q, s7_b_q, s7_a2_q, s8_m_q, s8_num_q, s9_num_q;
  logic [30:0] s9_div_q;
  logic        s9_inv_q;
  logic [63:0] s10_ma_q;
  logic [30:0] s10_mb_q;
  bpt_side_t   s10_side_q;

  logic        dv_valid;
  logic [63:0] dv_quot;
  bpt_side_t   dv_side;

  logic [63:0] q0_p_q, q1_p_q, q1_sq_q, q1_pb_q, q2_p_q, q2_s2_q, q2_bb_q;
  logic [63:0] q3_p_q, q3_bb_q, q3_aa_q;
  logic [31:0] q1_cr_q;
  bpt_side_t   q0_side_q, q1_side_q, q2_side_q, q3_side_q;

  logic        out_v_q;
  bpt_out_t    out_q;

  // Combinational terms.
  logic [17:0] x1;
  logic [16:0] dt;
  logic [39:0] fsum;
  logic [31:0] fine_sat;
  logic [35:0] t5;
  logic [32:0] a33;
  logic [20:0] padc;
  logic [75:0] nprod;
  logic [63:0] s_sh, neg_num, rsum, rr;
  logic [31:0] pres;

  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    x1   = {1'b0, in_data_i.raw_temperature[19:3]} - {1'b0, cal_i.t1, 1'b0};
    dt   = {1'b0, in_data_i.raw_temperature[19:4]} - {1'b0, cal_i.t1};
    fsum = 40'($signed(s2_ta_q)) + 40'($signed(s2_tb_q) >>> 14);
    if (fsum[39] && (fsum[39:31] != 9'h1FF)) begin
      fine_sat = 32'h8000_0000;
    end else if (!fsum[39] && (fsum[38:31] != 8'h00)) begin
      fine_sat = 32'h7FFF_FFFF;
    end else begin
      fine_sat = fsum[31:0];
    end
    t5   = (36'($signed(s3_fine_q)) << 2) + 36'($signed(s3_fine_q)) + 36'd128;
    a33  = 33'($signed(s3_fine_q)) - FineOffset;
    padc = PAdcOffset - {1'b0, s7_adc_q};
    nprod = {12'b0, s8_num_q} * {64'b0, PScale};
    neg_num = 64'b0 - s9_num_q;
    s_sh = 64'($signed(q0_p_q) >>> 13);
    rsum = q3_p_q + q3_aa_q + q3_bb_q;
    rr   = 64'($signed(rsum) >>> 8) + (64'($signed(cal_i.p7)) << 4);
    if (q3_side_q.invalid || rr[63]) begin
      pres = 32'd0;
    end else if (rr[62:32] != 31'd0) begin
      pres = 32'hFFFF_FFFF;
    end else begin
      pres = rr[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      qv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q     <= {v_q[8:0], in_valid_i};
      qv_q    <= {qv_q[2:0], dv_valid};
      out_v_q <= qv_q[3];
    end
  end

  // v_q tracks the stages ahead of the divider, the divider carries its own
  // valid bits, and qv_q tracks the stages after it.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Temperature.
      s1_ta_q   <= 34'($signed(x1) * $signed(cal_i.t2));
      s1_dd_q   <= 34'($signed(dt) * $signed(dt));
      s1_adc_q  <= in_data_i.raw_pressure;
      s2_ta_q   <= 23'($signed(s1_ta_q) >>> 11);
      s2_tb_q   <= 38'($signed({1'b0, s1_dd_q[32:12]}) * $signed(cal_i.t3));
      s2_adc_q  <= s1_adc_q;
      s3_fine_q <= fine_sat;
      s3_adc_q  <= s2_adc_q;
      s4_temp_q <= {{4{t5[35]}}, t5[35:8]};
      s4_fine_q <= s3_fine_q;
      s4_a_q    <= a33;
      s4_absa_q <= a33[32] ? 32'(33'b0 - a33) : a33[31:0];
      s4_adc_q  <= s3_adc_q;
      // Pressure divisor and numerator.
      s5_asq_q  <= {32'b0, s4_absa_q} * {32'b0, s4_absa_q};
      s5_ap5_q  <= 49'($signed(s4_a_q) * $signed(cal_i.p5));
      s5_ap2_q  <= 49'($signed(s4_a_q) * $signed(cal_i.p2));
      s5_temp_q <= s4_temp_q;
      s5_fine_q <= s4_fine_q;
      s5_adc_q  <= s4_adc_q;
      s6_b1_q   <= mul_s64_s16(s5_asq_q, cal_i.p6);
      s6_a1_q   <= mul_s64_s16(s5_asq_q, cal_i.p3);
      s6_ap5_q  <= s5_ap5_q;
      s6_ap2_q  <= s5_ap2_q;
      s6_temp_q <= s5_temp_q;
      s6_fine_q <= s5_fine_q;
      s6_adc_q  <= s5_adc_q;
      s7_b_q    <= s6_b1_q + (64'($signed(s6_ap5_q)) << 17) + (64'($signed(cal_i.p4)) << 35);
      s7_a2_q   <= 64'($signed(s6_a1_q) >>> 8) + (64'($signed(s6_ap2_q)) << 12);
      s7_temp_q <= s6_temp_q;
      s7_fine_q <= s6_fine_q;
      s7_adc_q  <= s6_adc_q;
      s8_m_q    <= mul_u64_u16(POne47 + s7_a2_q, cal_i.p1);
      s8_num_q  <= ({43'b0, padc} << 31) - s7_b_q;
      s8_temp_q <= s7_temp_q;
      s8_fine_q <= s7_fine_q;
      s9_div_q  <= s8_m_q[63:33];
      s9_inv_q  <= (s8_m_q[63:33] == 31'd0);
      s9_num_q  <= nprod[63:0];
      s9_temp_q <= s8_temp_q;
      s9_fine_q <= s8_fine_q;
      // Split into magnitudes and a quotient sign for the divider.
      s10_ma_q  <= s9_num_q[63] ? neg_num : s9_num_q;
      s10_mb_q  <= s9_div_q[30] ? (31'b0 - s9_div_q) : s9_div_q;
      s10_side_q.temp    <= s9_temp_q;
      s10_side_q.fine    <= s9_fine_q;
      s10_side_q.invalid <= s9_inv_q;
      s10_side_q.qneg    <= s9_num_q[63] ^ s9_div_q[30];
      // After the divider.
      q0_p_q    <= dv_side.qneg ? (64'b0 - dv_quot) : dv_quot;
      q0_side_q <= dv_side;
      q1_sq_q   <= {32'b0, s_sh[31:0]} * {32'b0, s_sh[31:0]};
      q1_cr_q   <= 32'(s_sh[31:0] * s_sh[63:32]);
      q1_pb_q   <= mul_s64_s16(q0_p_q, cal_i.p8);
      q1_p_q    <= q0_p_q;
      q1_side_q <= q0_side_q;
      // Square of the shifted pressure modulo 2^64 from its two halves.
      q2_s2_q   <= q1_sq_q + {q1_cr_q[30:0], 33'b0};
      q2_bb_q   <= 64'($signed(q1_pb_q) >>> 19);
      q2_p_q    <= q1_p_q;
      q2_side_q <= q1_side_q;
      q3_aa_q   <= 64'($signed(mul_s64_s16(q2_s2_q, cal_i.p9)) >>> 25);
      q3_bb_q   <= q2_bb_q;
      q3_p_q    <= q2_p_q;
      q3_side_q <= q2_side_q;
      out_q.temperature_centi <= q3_side_q.temp;
      out_q.fine_temperature  <= q3_side_q.fine;
      out_q.pressure_q24_8    <= pres;
      out_q.pressure_invalid  <= q3_side_q.invalid;
    end
  end

  bpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (v_q[9]),
    .dividend_i (s10_ma_q),
    .divisor_i  (s10_mb_q),
    .side_i     (s10_side_q),
    .valid_o    (dv_valid),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

/* src/baro_pressure_temp_compensation.sv */
// Channel   Signals                               Direction
// input     in_valid_i / in_ready_o / in_data_i   raw pressure and temperature in
// output    out_valid_o / out_ready_i / out_data_o compensated result out
// config    cfg_we_i / cfg_idx_i / cfg_wdata_i    calibration register writes
//
// One transaction enters per clock while the output is not stalled; the datapath is a fully pipelined chain
// whose length is set by the 64-bit divide, two quotient bits per stage.
// A transaction passes the input queue, the stages before and after the divider and the output register.
// Reset clears the calibration registers, the input queue and all valid bits.
// A stalled output freezes the whole pipeline; the two-entry input queue
// keeps taking transactions until it fills.
module baro_pressure_temp_compensation import bpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bpt_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bpt_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CalIdxW-1:0] cfg_idx_i,
  input  logic [CalW-1:0]    cfg_wdata_i
);

  bpt_cal_t cal;
  logic     q_valid, q_ready;
  bpt_in_t  q_data;

  bpt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cal_o       (cal)
  );

  bpt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_data_o   (q_data)
  );

  bpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_data_i   (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/tb_baro_pressure_temp_compensation.sv */
`timescale 1ns / 100ps

module tb_baro_pressure_temp_compensation import bpt_pkg::*;;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  bpt_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  bpt_out_t            out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CalIdxW-1:0]  cfg_idx_i = '0;
  logic [CalW-1:0]     cfg_wdata_i = '0;

  baro_pressure_temp_compensation dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #10 clk_i = ~clk_i;

  logic [31:0] cal_regs [NumCal];
  bpt_in_t     sample_q [$];
  bpt_out_t    result_q [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off = 0;
  int          errors = 0;

  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic signed [63:0] clamp_s32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Computes the compensated result from the current calibration words.
  function automatic bpt_out_t compensate(input bpt_in_t s);
    logic signed [63:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] a, b, d, fine, temp, p;
    bpt_out_t r;
    adc_p = {44'd0, s.raw_pressure};
    adc_t = {44'd0, s.raw_temperature};
    t1 = {48'd0, cal_regs[0][15:0]};
    t2 = sx16(cal_regs[0][31:16]);
    t3 = sx16(cal_regs[1][15:0]);
    p1 = {48'd0, cal_regs[1][31:16]};
    p2 = sx16(cal_regs[2][15:0]);  p3 = sx16(cal_regs[2][31:16]);
    p4 = sx16(cal_regs[3][15:0]);  p5 = sx16(cal_regs[3][31:16]);
    p6 = sx16(cal_regs[4][15:0]);  p7 = sx16(cal_regs[4][31:16]);
    p8 = sx16(cal_regs[5][15:0]);  p9 = sx16(cal_regs[5][31:16]);
    a = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d = (adc_t >>> 4) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    fine = clamp_s32(a + b);
    temp = clamp_s32((fine * 5 + 128) >>> 8);
    r.temperature_centi = temp[31:0];
    r.fine_temperature = fine[31:0];
    r.pressure_invalid = 1'b0;
    a = fine - 128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    if (a == 0) begin
      r.pressure_q24_8 = '0;
      r.pressure_invalid = 1'b1;
    end else begin
      p = 64'sd1048576 - adc_p;
      p = (((p <<< 31) - b) * 3125);
      // Signed divide truncates toward zero; min / -1 wraps to itself.
      if (a == -64'sd1) p = -p;
      else p = p / a;
      a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      b = (p8 * p) >>> 19;
      p = ((p + a + b) >>> 8) + (p7 <<< 4);
      if (p < 0) r.pressure_q24_8 = '0;
      else if (p > 64'sd4294967295) r.pressure_q24_8 = '1;
      else r.pressure_q24_8 = p[31:0];
    end
    return r;
  endfunction

  // Driver: presents queued samples and honors the handshake.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      result_q.push_back(compensate(in_data_i));
    end
    if (!in_valid_i || in_ready_o) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= sample_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks every completed transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        bpt_out_t e;
        e = result_q.pop_front();
        if (e.temperature_centi !== out_data_o.temperature_centi) begin
          $display("%0t: temperature_centi expected %0d actual %0d", $time,
                   e.temperature_centi, out_data_o.temperature_centi);
          errors++;
        end
        if (e.fine_temperature !== out_data_o.fine_temperature) begin
          $display("%0t: fine_temperature expected %0d actual %0d", $time,
                   e.fine_temperature, out_data_o.fine_temperature);
          errors++;
        end
        if (e.pressure_q24_8 !== out_data_o.pressure_q24_8) begin
          $display("%0t: pressure_q24_8 expected %h actual %h", $time,
                   e.pressure_q24_8, out_data_o.pressure_q24_8);
          errors++;
        end
        if (e.pressure_invalid !== out_data_o.pressure_invalid) begin
          $display("%0t: pressure_invalid expected %b actual %b", $time,
                   e.pressure_invalid, out_data_o.pressure_invalid);
          errors++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_cal(input logic [CalIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx < NumCal) cal_regs[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (sample_q.size() == 0 && !in_valid_i);
    @(posedge clk_i);
    wait (result_q.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  // A typical, sane calibration set with optional random perturbation around it.
  task automatic load_typical(input bit jitter);
    logic [15:0] w [12];
    w = '{16'd27504, 16'd26435, 16'hfc18, 16'd36477, 16'hd6d0, 16'd3024,
          16'd2855, 16'd140, 16'hfff9, 16'd15500, 16'hd408, 16'd6000};
    if (jitter) foreach (w[i]) w[i] = w[i] + 16'($urandom_range(200)) - 16'd100;
    write_cal(CalT1T2, {w[1], w[0]});
    write_cal(CalT3P1, {w[3], w[2]});
    write_cal(CalP2P3, {w[5], w[4]});
    write_cal(CalP4P5, {w[7], w[6]});
    write_cal(CalP6P7, {w[9], w[8]});
    write_cal(CalP8P9, {w[11], w[10]});
  endtask

  function automatic bpt_in_t rand_sample();
    bpt_in_t s;
    s.raw_pressure = 20'($urandom);
    s.raw_temperature = 20'($urandom);
    if ($urandom_range(3) != 0) begin
      s.raw_pressure = 20'($urandom_range(250000, 450000));
      s.raw_temperature = 20'($urandom_range(400000, 600000));
    end
    return s;
  endfunction

  initial begin
    foreach (cal_regs[i]) cal_regs[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero calibration: divisor is zero, so pressure is flagged invalid.
    sample_q.push_back('{20'd0, 20'd0});
    sample_q.push_back('{20'hfffff, 20'hfffff});
    drain();

    load_typical(1'b0);
    write_cal(3'd7, 32'hdeadbeef);  // out of range index, ignored
    sample_q.push_back('{20'd0, 20'd0});
    sample_q.push_back('{20'hfffff, 20'hfffff});
    sample_q.push_back('{20'd0, 20'hfffff});
    sample_q.push_back('{20'hfffff, 20'd0});
    sample_q.push_back('{20'd415148, 20'd519888});
    sample_q.push_back('{20'h55555, 20'haaaaa});
    sample_q.push_back('{20'haaaaa, 20'h55555});
    drain();

    // Extreme coefficients: all ones, maximum positive and sign bits only, saturating paths.
    foreach (cal_regs[i]) write_cal(i[CalIdxW-1:0], 32'hffffffff);
    sample_q.push_back('{20'd0, 20'hfffff});
    sample_q.push_back('{20'hfffff, 20'd0});
    drain();
    foreach (cal_regs[i]) write_cal(i[CalIdxW-1:0], 32'h7fff7fff);
    sample_q.push_back('{20'd0, 20'hfffff});
    sample_q.push_back('{20'h80000, 20'd0});
    drain();
    foreach (cal_regs[i]) write_cal(i[CalIdxW-1:0], 32'h80008000);
    sample_q.push_back('{20'd0, 20'hfffff});
    sample_q.push_back('{20'hfffff, 20'h12345});
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if (ph == 5) foreach (cal_regs[i]) write_cal(i[CalIdxW-1:0], $urandom);
      else load_typical(1'b1);
      for (int k = 0; k < 230; k++) sample_q.push_back(rand_sample());
      if (ph == 0) begin
        // Long receiver hold-off while the sender keeps offering items.
        @(posedge clk_i);
        hold_off = 300;
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
src/bpt_pkg.sv
src/bpt_cfg.sv
src/bpt_front.sv
src/bpt_div.sv
src/bpt_back.sv
src/baro_pressure_temp_compensation.sv
tb/tb_baro_pressure_temp_compensation.sv
